// File: rtl/mse_pkg.sv
package mse_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;

  typedef enum logic [3:0] {
    ST_DONE    = 4'd0,
    ST_TAKEN   = 4'd1,
    ST_PINT    = 4'd2,
    ST_PCHAR   = 4'd3,
    ST_EXIT    = 4'd4,
    ST_UNKNOWN = 4'd5,
    ST_INVALID = 4'd6,
    ST_HALTED  = 4'd7,
    ST_READ    = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    K_READ, K_ADD, K_SUB, K_AND, K_OR, K_SLT, K_MUL, K_BEQ, K_BNE,
    K_ADDI, K_SLTI, K_ANDI, K_ORI, K_LUI, K_SYSCALL, K_INVALID
  } kind_t;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_MUL   = 6'd28;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SYS   = 6'd12;
  localparam logic [5:0] FN_MUL   = 6'd2;

  localparam logic [31:0] SYS_PINT  = 32'd1;
  localparam logic [31:0] SYS_PCHAR = 32'd11;
  localparam logic [31:0] SYS_EXIT  = 32'd10;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
  } uop_t;

endpackage

// File: rtl/mse_front.sv
module mse_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_action,
  input  logic [31:0]   in_instruction,
  input  logic [4:0]    in_read_index,
  output logic          q_valid,
  input  logic          q_ready,
  output mse_pkg::uop_t q_uop
);
  import mse_pkg::*;

  uop_t              mem_r [QDepth];
  logic [QPtrW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPtrW:0]    cnt_r, cnt_nxt;
  uop_t              dec;
  logic [5:0]        op, fn;
  logic              push, pop;

  assign op = in_instruction[31:26];
  assign fn = in_instruction[5:0];

  always_comb begin
    dec.rs   = in_instruction[25:21];
    dec.rt   = in_instruction[20:16];
    dec.rd   = in_instruction[15:11];
    dec.imm  = in_instruction[15:0];
    dec.kind = K_INVALID;
    if (in_action) begin
      dec.kind = K_READ;
      dec.rs   = in_read_index;
    end else if (op == OP_RTYPE) begin
      unique case (fn)
        FN_ADD:  dec.kind = K_ADD;
        FN_SUB:  dec.kind = K_SUB;
        FN_AND:  dec.kind = K_AND;
        FN_OR:   dec.kind = K_OR;
        FN_SLT:  dec.kind = K_SLT;
        FN_SYS:  dec.kind = K_SYSCALL;
        default: dec.kind = K_INVALID;
      endcase
    end else if (op == OP_MUL) begin
      dec.kind = (fn == FN_MUL) ? K_MUL : K_INVALID;
    end else begin
      unique case (op)
        OP_BEQ:  dec.kind = K_BEQ;
        OP_BNE:  dec.kind = K_BNE;
        OP_ADDI: dec.kind = K_ADDI;
        OP_SLTI: dec.kind = K_SLTI;
        OP_ANDI: dec.kind = K_ANDI;
        OP_ORI:  dec.kind = K_ORI;
        OP_LUI:  dec.kind = K_LUI;
        default: dec.kind = K_INVALID;
      endcase
    end
  end

  assign in_ready = (cnt_r != (QPtrW+1)'(QDepth));
  assign q_valid  = (cnt_r != '0);
  assign q_uop    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= dec;
    end
  end
endmodule

// File: rtl/mse_back.sv
module mse_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  mse_pkg::uop_t q_uop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    out_status,
  output logic [31:0]   out_value,
  output logic [15:0]   out_pc_step
);
  import mse_pkg::*;

  logic [31:0] rf_r [32];
  logic        halted_r, halted_nxt;
  logic        ov_r, ov_nxt;
  logic [3:0]  st_r, st_nxt;
  logic [31:0] val_r, val_nxt;
  logic [15:0] step_r, step_nxt;
  logic [31:0] a, b, simm, v0, a0, wdata;
  logic [4:0]  wreg;
  logic        we, fire;

  assign q_ready = !ov_r || out_ready;
  assign fire    = q_valid && q_ready;
  assign a    = (q_uop.rs == 5'd0) ? 32'd0 : rf_r[q_uop.rs];
  assign b    = (q_uop.rt == 5'd0) ? 32'd0 : rf_r[q_uop.rt];
  assign v0   = rf_r[2];
  assign a0   = rf_r[4];
  assign simm = {{16{q_uop.imm[15]}}, q_uop.imm};

  always_comb begin
    status_t s;
    s          = ST_DONE;
    val_nxt    = 32'd0;
    step_nxt   = 16'd1;
    wdata      = 32'd0;
    wreg       = q_uop.rt;
    we         = 1'b0;
    halted_nxt = halted_r;
    if (q_uop.kind == K_READ) begin
      s       = ST_READ;
      val_nxt = a;
    end else if (halted_r) begin
      s = ST_HALTED;
    end else begin
      unique case (q_uop.kind)
        K_ADD:  begin we = 1'b1; wreg = q_uop.rd; wdata = a + b; end
        K_SUB:  begin we = 1'b1; wreg = q_uop.rd; wdata = a - b; end
        K_AND:  begin we = 1'b1; wreg = q_uop.rd; wdata = a & b; end
        K_OR:   begin we = 1'b1; wreg = q_uop.rd; wdata = a | b; end
        K_SLT:  begin
          we = 1'b1; wreg = q_uop.rd; wdata = {31'd0, $signed(a) < $signed(b)};
        end
        K_MUL:  begin we = 1'b1; wreg = q_uop.rd; wdata = a * b; end
        K_BEQ:  if (a == b) begin s = ST_TAKEN; step_nxt = q_uop.imm; end
        K_BNE:  if (a != b) begin s = ST_TAKEN; step_nxt = q_uop.imm; end
        K_ADDI: begin we = 1'b1; wdata = a + simm; end
        K_SLTI: begin we = 1'b1; wdata = {31'd0, $signed(a) < $signed(simm)}; end
        K_ANDI: begin we = 1'b1; wdata = a & simm; end
        K_ORI:  begin we = 1'b1; wdata = a | simm; end
        K_LUI:  begin we = 1'b1; wdata = {q_uop.imm, 16'd0}; end
        K_SYSCALL: begin
          if (v0 == SYS_PINT) begin
            s = ST_PINT; val_nxt = a0;
          end else if (v0 == SYS_PCHAR) begin
            s = ST_PCHAR; val_nxt = {24'd0, a0[7:0]};
          end else if (v0 == SYS_EXIT) begin
            s = ST_EXIT; halted_nxt = 1'b1;
          end else begin
            s = ST_UNKNOWN; val_nxt = v0; halted_nxt = 1'b1;
          end
        end
        default: s = ST_INVALID;
      endcase
    end
    st_nxt = s;
    if (!fire) begin
      halted_nxt = halted_r;
      we         = 1'b0;
    end
    ov_nxt = fire ? 1'b1 : (ov_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      ov_r     <= ov_nxt;
      halted_r <= halted_nxt;
    end
  end

  // The register file clears at reset so that every entry starts at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) rf_r[i] <= 32'd0;
    end else if (we && wreg != 5'd0) begin
      rf_r[wreg] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      st_r   <= st_nxt;
      val_r  <= val_nxt;
      step_r <= step_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign out_status  = st_r;
  assign out_value   = val_r;
  assign out_pc_step = step_r;
endmodule

// File: rtl/mips_subset_execute_core.sv
// Execute core for a small MIPS subset with a 32-entry register file.
// Input channel (in_valid/in_ready): in_action 0 executes in_instruction,
// in_action 1 reads register in_read_index. Each transaction gives exactly
// one result transaction on out_valid/out_ready with out_status, out_value
// and out_pc_step.
// A decoder front end writes classified operations into a two-entry queue;
// the back end reads the register file, executes (one 32x32 multiply), writes
// back and registers the result at the same clock edge.
// An accepted transaction is registered in the queue, then in the output register.
// Throughput is one transaction per cycle while the receiver keeps out_ready high.
// Reset (rst_n low, synchronous) clears the register file, the halt flag,
// the queue and the output valid flag.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and in_ready drops after two more transactions.
module mips_subset_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_instruction,
  input  logic [4:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic signed [31:0] out_value,
  output logic signed [15:0] out_pc_step
);
  import mse_pkg::*;

  logic q_valid, q_ready;
  uop_t q_uop;

  mse_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_instruction,
    .in_read_index, .q_valid, .q_ready, .q_uop
  );

  mse_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_uop, .out_valid, .out_ready,
    .out_status, .out_value, .out_pc_step
  );
endmodule

// File: rtl/mse_checker.sv
module mse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_status,
  input logic [15:0] out_pc_step
);
  import mse_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn before acceptance");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TAKEN |-> out_pc_step == 16'd1)
    else $error("pc step must be one unless a branch is taken");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_READ)
    else $error("status code out of range");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");
endmodule

bind mips_subset_execute_core mse_checker u_mse_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_pc_step
);

// File: tb/tb_mips_subset_execute_core.sv
`timescale 1ns / 1ps

module tb_mips_subset_execute_core;
  import mse_pkg::*;

  typedef struct {
    logic        action;
    logic [31:0] word;
    logic [4:0]  ridx;
  } instr_item_t;

  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [15:0] step;
  } retire_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_action;
  logic [31:0] in_instruction;
  logic [4:0] in_read_index;
  logic out_valid;
  logic out_ready;
  logic [3:0] out_status;
  logic signed [31:0] out_value;
  logic signed [15:0] out_pc_step;

  mips_subset_execute_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_instruction(in_instruction),
    .in_read_index(in_read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_value(out_value), .out_pc_step(out_pc_step)
  );

  instr_item_t pending_q[$];
  retire_t     retire_q[$];
  logic [31:0] arch_regs[32];
  logic        arch_halted;
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] reg_rd(logic [4:0] n);
    return (n == 5'd0) ? 32'd0 : arch_regs[n];
  endfunction

  // Updates the architectural state and returns the result of one transaction.
  function automatic retire_t execute_instr(instr_item_t it);
    retire_t r;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, dst;
    logic [31:0] a, b, simm, wv, v0, a0;
    logic wen;
    r.status = ST_DONE;
    r.value = 32'd0;
    r.step = 16'd1;
    op = it.word[31:26];
    fn = it.word[5:0];
    rs = it.word[25:21];
    rt = it.word[20:16];
    rd = it.word[15:11];
    simm = {{16{it.word[15]}}, it.word[15:0]};
    a = reg_rd(rs);
    b = reg_rd(rt);
    wen = 1'b0;
    dst = rt;
    wv = 32'd0;
    if (it.action) begin
      r.status = ST_READ;
      r.value = reg_rd(it.ridx);
    end else if (arch_halted) begin
      r.status = ST_HALTED;
    end else if (op == OP_RTYPE) begin
      dst = rd;
      wen = 1'b1;
      case (fn)
        FN_ADD: wv = a + b;
        FN_SUB: wv = a - b;
        FN_AND: wv = a & b;
        FN_OR:  wv = a | b;
        FN_SLT: wv = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        FN_SYS: begin
          wen = 1'b0;
          v0 = reg_rd(5'd2);
          a0 = reg_rd(5'd4);
          if (v0 == SYS_PINT) begin
            r.status = ST_PINT;
            r.value = a0;
          end else if (v0 == SYS_PCHAR) begin
            r.status = ST_PCHAR;
            r.value = {24'd0, a0[7:0]};
          end else if (v0 == SYS_EXIT) begin
            r.status = ST_EXIT;
            arch_halted = 1'b1;
          end else begin
            r.status = ST_UNKNOWN;
            r.value = v0;
            arch_halted = 1'b1;
          end
        end
        default: begin
          wen = 1'b0;
          r.status = ST_INVALID;
        end
      endcase
    end else if (op == OP_MUL) begin
      if (fn == FN_MUL) begin
        dst = rd;
        wen = 1'b1;
        wv = a * b;
      end else begin
        r.status = ST_INVALID;
      end
    end else begin
      wen = 1'b1;
      case (op)
        OP_BEQ: begin
          wen = 1'b0;
          if (a == b) begin
            r.status = ST_TAKEN;
            r.step = it.word[15:0];
          end
        end
        OP_BNE: begin
          wen = 1'b0;
          if (a != b) begin
            r.status = ST_TAKEN;
            r.step = it.word[15:0];
          end
        end
        OP_ADDI: wv = a + simm;
        OP_SLTI: wv = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        OP_ANDI: wv = a & simm;
        OP_ORI:  wv = a | simm;
        OP_LUI:  wv = {it.word[15:0], 16'd0};
        default: begin
          wen = 1'b0;
          r.status = ST_INVALID;
        end
      endcase
    end
    if (wen && dst != 5'd0) arch_regs[dst] = wv;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  task automatic push_exec(logic [31:0] w);
    instr_item_t it;
    it.action = 1'b0;
    it.word = w;
    it.ridx = 5'($urandom);
    pending_q.push_back(it);
  endtask

  task automatic push_read(logic [4:0] n);
    instr_item_t it;
    it.action = 1'b1;
    it.word = $urandom;
    it.ridx = n;
    pending_q.push_back(it);
  endtask

  // Mostly well-formed instructions on a few hot registers, so that branch
  // comparisons hit often; the rest is raw noise. Deliberate syscalls come from the
  // phase loop, right after a print selector is loaded into $v0.
  function automatic logic [31:0] random_word();
    logic [4:0] rs, rt, rd;
    logic [15:0] imm;
    logic [5:0] nf;
    int pick;
    rs = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
    rt = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
    rd = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
    case ($urandom_range(0, 3))
      0: imm = 16'($urandom);
      1: imm = 16'($urandom_range(0, 12));
      2: imm = 16'hFFFF - 16'($urandom_range(0, 3));
      default: imm = {$urandom_range(0, 1) ? 16'h8000 : 16'h7FFF};
    endcase
    nf = 6'($urandom);
    if (nf == FN_SYS) nf = 6'd0;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return enc_r(rs, rt, rd, FN_ADD);
      1: return enc_r(rs, rt, rd, FN_SUB);
      2: return enc_r(rs, rt, rd, FN_AND);
      3: return enc_r(rs, rt, rd, FN_OR);
      4: return enc_r(rs, rt, rd, FN_SLT);
      5: return {OP_MUL, rs, rt, rd, 5'($urandom), FN_MUL};
      6: return enc_i(OP_BEQ, rs, rt, imm);
      7: return enc_i(OP_BNE, rs, rt, imm);
      8, 9: return enc_i(OP_ADDI, rs, rt, imm);
      10: return enc_i(OP_SLTI, rs, rt, imm);
      11: return enc_i(OP_ANDI, rs, rt, imm);
      12: return enc_i(OP_ORI, rs, rt, imm);
      13: return enc_i(OP_LUI, rs, rt, imm);
      14: return enc_i(OP_ADDI, 5'd0, 5'd4, imm);
      15: return enc_i(OP_ADDI, 5'd0, 5'd2, 16'($urandom_range(0, 12)));
      16: return enc_i(OP_ADDI, 5'd0, 5'd2, $urandom_range(0, 1) ? 16'd1 : 16'd11);
      17: return {OP_RTYPE, 20'($urandom), nf};
      18: return {OP_MUL, 20'($urandom), 6'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || retire_q.size() != 0) @(posedge clk);
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        instr_item_t it;
        it = pending_q.pop_front();
        retire_q.push_back(execute_instr(it));
        in_valid <= 1'b1;
        in_action <= it.action;
        in_instruction <= it.word;
        in_read_index <= it.ridx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver with random stalls and an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (retire_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", out_status);
      end else begin
        retire_t e;
        e = retire_q.pop_front();
        if (out_status !== e.status || out_value !== e.value || out_pc_step !== e.step) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status=%0d value=%h step=%h got status=%0d value=%h step=%h",
                     e.status, e.value, e.step, out_status, out_value, out_pc_step);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int i, n, r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_instruction = 32'd0;
    in_read_index = 5'd0;
    out_ready = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    arch_halted = 1'b0;
    for (i = 0; i < 32; i++) arch_regs[i] = 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, each operation, register 0 and the print syscalls.
    push_exec(enc_i(OP_LUI, 5'd0, 5'd3, 16'hFFFF));
    push_exec(enc_i(OP_ORI, 5'd3, 5'd3, 16'h8000));
    push_exec(enc_i(OP_ADDI, 5'd0, 5'd5, 16'h7FFF));
    push_exec(enc_i(OP_ADDI, 5'd0, 5'd0, 16'h1234));
    push_exec(enc_r(5'd3, 5'd5, 5'd6, FN_ADD));
    push_exec(enc_r(5'd5, 5'd3, 5'd7, FN_SUB));
    push_exec(enc_r(5'd3, 5'd5, 5'd8, FN_AND));
    push_exec(enc_r(5'd3, 5'd5, 5'd9, FN_OR));
    push_exec(enc_r(5'd3, 5'd5, 5'd10, FN_SLT));
    push_exec({OP_MUL, 5'd3, 5'd3, 5'd11, 5'd31, FN_MUL});
    push_exec(enc_i(OP_SLTI, 5'd3, 5'd12, 16'h8000));
    push_exec(enc_i(OP_ANDI, 5'd3, 5'd13, 16'h8001));
    push_exec(enc_i(OP_BEQ, 5'd0, 5'd0, 16'd0));
    push_exec(enc_i(OP_BNE, 5'd3, 5'd5, 16'h8000));
    push_exec(enc_i(OP_BEQ, 5'd3, 5'd5, 16'h7FFF));
    push_exec(32'hFFFF_FFFF);
    push_exec({OP_MUL, 20'd0, 6'd3});
    push_exec(enc_i(OP_ADDI, 5'd0, 5'd4, 16'hFF41));
    push_exec(enc_i(OP_ADDI, 5'd0, 5'd2, 16'd1));
    push_exec({OP_RTYPE, 20'hFFFFF, FN_SYS});
    push_exec(enc_i(OP_ADDI, 5'd0, 5'd2, 16'd11));
    push_exec({OP_RTYPE, 20'd0, FN_SYS});
    push_exec(enc_i(OP_ADDI, 5'd0, 5'd6, 16'd1));
    push_read(5'd0);
    push_read(5'd31);
    push_read(5'd3);
    wait_drained();

    // Random phases. A halted core stays halted until reset, so the phase loop's
    // syscalls always follow a print selector and the halt comes last.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 300; end
      endcase
      n = (ph == 4) ? 44 : 220;
      for (i = 0; i < n; i++) begin
        r = $urandom_range(0, 7);
        if (r == 0) begin
          push_read(5'($urandom));
        end else if (r == 1) begin
          push_exec(enc_i(OP_ADDI, 5'd0, 5'd2, $urandom_range(0, 1) ? 16'd1 : 16'd11));
          push_exec({OP_RTYPE, 20'($urandom), FN_SYS});
        end else begin
          push_exec(random_word());
        end
      end
      wait_drained();
    end

    // Halt by exit or by an unknown syscall, then check that execution stops
    // while register reads still work.
    push_exec(enc_i(OP_ADDI, 5'd0, 5'd2, $urandom_range(0, 1) ? 16'd10 : 16'd7));
    push_exec({OP_RTYPE, 20'd0, FN_SYS});
    push_exec(enc_i(OP_ADDI, 5'd0, 5'd6, 16'd1));
    push_read(5'd6);
    push_read(5'd2);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && retire_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mse_pkg.sv
rtl/mse_front.sv
rtl/mse_back.sv
rtl/mips_subset_execute_core.sv
rtl/mse_checker.sv
tb/tb_mips_subset_execute_core.sv
